[rtl/rcd_pkg.sv]
// Shared types and constants for the restricted circular deque.
package rcd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        OP_INS_R = 2'd0,
        OP_INS_L = 2'd1,
        OP_DEL_L = 2'd2,
        OP_DEL_R = 2'd3
    } req_op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OVERFLOW    = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_NOT_ALLOWED = 2'd3
    } req_status_t;

    typedef enum logic {
        MODE_IN_RESTRICTED  = 1'b0,
        MODE_OUT_RESTRICTED = 1'b1
    } restrict_mode_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_WAIT = 1'b1
    } ctrl_state_t;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic              ins_r;
        logic              ins_l;
        logic              del_l;
        logic              del_r;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

[rtl/rcd_cell.sv]
// One slot of the deque chain: a data word plus a return-lane stage.
module rcd_cell
    import rcd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                         aclk,
    input  cell_cmd_t                    cmd,
    input  logic [$clog2(DEPTH+1)-1:0]   fill,
    input  logic [WORD_W-1:0]            left_data,
    input  logic [WORD_W-1:0]            right_data,
    input  logic [WORD_W-1:0]            right_lane,
    output logic [WORD_W-1:0]            data_out,
    output logic [WORD_W-1:0]            lane_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] SLOT      = CW'(INDEX);
    localparam logic [CW-1:0] SLOT_NEXT = CW'(INDEX + 1);

    logic [WORD_W-1:0] data_reg, data_next;
    logic [WORD_W-1:0] lane_reg, lane_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins_l) begin
            data_next = left_data;
        end else if (cmd.del_l) begin
            data_next = right_data;
        end else if (cmd.ins_r && (fill == SLOT)) begin
            data_next = cmd.word;
        end
    end

    // Tail slot drops its word onto the lane; the lane walks toward slot 0
    assign lane_next = (cmd.del_r && (fill == SLOT_NEXT)) ? data_reg : right_lane;

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        lane_reg <= lane_next;
    end

    assign data_out = data_reg;
    assign lane_out = lane_reg;

endmodule

[rtl/rcd_ctrl.sv]
// Request control: mode register, fill count, status decisions and result register.
module rcd_ctrl
    import rcd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [WORD_W-1:0]            s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [WORD_W-1:0]            m_removed_value,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count,
    input  logic [WORD_W-1:0]            head_data,
    input  logic [WORD_W-1:0]            head_lane,
    output cell_cmd_t                    cmd,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [2:0] ADDR_MODE = 3'd0;

    ctrl_state_t    state_reg, state_next;
    restrict_mode_t mode_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  wait_reg, wait_next;

    logic              m_valid_reg;
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] removed_reg;
    logic [CW-1:0]     fill_reg;

    req_op_t       op;
    req_status_t   res_status;
    logic          accept, cfg_write, op_ok, del_r_ok, load_now, load_late;
    logic          not_allowed;
    logic [WORD_W-1:0] res_removed;

    assign op        = req_op_t'(s_req_type);
    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_MODE);
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign not_allowed = ((mode_reg == MODE_IN_RESTRICTED) && (op == OP_INS_L)) ||
                         ((mode_reg == MODE_OUT_RESTRICTED) && (op == OP_DEL_R));

    always_comb begin
        res_status = ST_OK;
        if (not_allowed) begin
            res_status = ST_NOT_ALLOWED;
        end else if ((op == OP_INS_R) || (op == OP_INS_L)) begin
            if (count_reg == FULL) res_status = ST_OVERFLOW;
        end else begin
            if (count_reg == '0) res_status = ST_UNDERFLOW;
        end
    end

    assign op_ok    = accept && (res_status == ST_OK);
    assign del_r_ok = op_ok && (op == OP_DEL_R);
    assign load_now = accept && !del_r_ok;

    // Broadcast to the chain only for requests that change state
    always_comb begin
        cmd.ins_r = op_ok && (op == OP_INS_R);
        cmd.ins_l = op_ok && (op == OP_INS_L);
        cmd.del_l = op_ok && (op == OP_DEL_L);
        cmd.del_r = del_r_ok;
        cmd.word  = s_value;
    end
    assign fill = count_reg;

    assign res_removed = (op_ok && (op == OP_DEL_L)) ? head_data : '0;

    always_comb begin
        count_next = count_reg;
        if (cfg_write) begin
            count_next = '0;
        end else if (op_ok) begin
            if ((op == OP_INS_R) || (op == OP_INS_L)) count_next = count_reg + 1'b1;
            else                                      count_next = count_reg - 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: if (del_r_ok) state_next = CS_WAIT;
            CS_WAIT: if (wait_reg == '0) state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready   = 1'b0;
        load_late = 1'b0;
        case (state_reg)
            CS_IDLE: s_ready = !m_valid_reg || m_ready;
            CS_WAIT: load_late = (wait_reg == '0);
            default: ;
        endcase
    end

    // Lane distance from the tail slot down to slot 0
    always_comb begin
        wait_next = wait_reg;
        if (del_r_ok) begin
            wait_next = IW'(count_reg - 1'b1);
        end else if (wait_reg != '0) begin
            wait_next = wait_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            mode_reg    <= MODE_IN_RESTRICTED;
            count_reg   <= '0;
            wait_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            if (cfg_write) mode_reg <= restrict_mode_t'(pwdata[0]);
            if (load_now || load_late) m_valid_reg <= 1'b1;
            else if (m_ready)          m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_now) begin
            status_reg  <= res_status;
            removed_reg <= res_removed;
            fill_reg    <= count_next;
        end else if (load_late) begin
            status_reg  <= ST_OK;
            removed_reg <= head_lane;
            fill_reg    <= count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_fill_count    = fill_reg;

endmodule

[rtl/restricted_circular_deque.sv]
// Top level of the restricted deque: controller plus the chain of storage cells.
//
// The deque is held as a chain of DEPTH cells with the left end always in cell 0, so a
// left insert or left delete shifts every cell one place and a right insert writes the
// first free cell. One request is taken at a time. Inserts, left deletes and every
// rejected request give their result in the cycle after acceptance. A right delete
// drops the tail word onto a return lane that moves one cell per cycle toward cell 0,
// and its result is loaded when the word reaches cell 0. Writing restrict_mode
// (address 0) empties the deque at once; there is no clearing pass after reset.
module restricted_circular_deque
    import rcd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic signed [WORD_W-1:0]     s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic signed [WORD_W-1:0]     m_removed_value,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count
);

    localparam int CW = $clog2(DEPTH + 1);

    cell_cmd_t         cmd;
    logic [CW-1:0]     fill;
    logic [WORD_W-1:0] data_w [DEPTH];
    logic [WORD_W-1:0] lane_w [DEPTH];
    logic [WORD_W-1:0] removed_u;

    rcd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (removed_u),
        .m_fill_count    (m_fill_count),
        .head_data       (data_w[0]),
        .head_lane       (lane_w[0]),
        .cmd             (cmd),
        .fill            (fill)
    );

    assign m_removed_value = removed_u;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_d, right_d, right_l;
        if (i == 0) begin : g_first
            assign left_d = cmd.word;
        end else begin : g_mid_l
            assign left_d = data_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
            assign right_l = '0;
        end else begin : g_mid_r
            assign right_d = data_w[i+1];
            assign right_l = lane_w[i+1];
        end
        rcd_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .fill       (fill),
            .left_data  (left_d),
            .right_data (right_d),
            .right_lane (right_l),
            .data_out   (data_w[i]),
            .lane_out   (lane_w[i])
        );
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.ins_r, cmd.ins_l, cmd.del_l, cmd.del_r}))
        else $error("more than one chain command at once");

    a_cmd_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins_r || cmd.ins_l || cmd.del_l || cmd.del_r) |-> (s_valid && s_ready))
        else $error("chain command without an accepted request");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OVERFLOW)) |-> (m_fill_count == CW'(DEPTH)))
        else $error("overflow reported while not full");

    a_reject_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_removed_value == '0))
        else $error("rejected request returned a word");

endmodule

[tb/restricted_circular_deque_test.sv]
// Self-checking testbench for the restricted circular deque: directed and random requests.
`timescale 1ns / 100ps

module restricted_circular_deque_test;
    import rcd_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AT    = 300;
    localparam int CALM_FROM  = 1100;
    localparam int CALM_TO    = 1600;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 106;

    typedef struct {
        req_status_t       status;
        logic [WORD_W-1:0] removed;
        logic [FILL_W-1:0] fill;
    } deque_answer_t;

    class deque_scoreboard;
        logic [WORD_W-1:0] words [DEPTH];
        int                left_pos;
        int                right_pos;
        int                held;
        restrict_mode_t    mode;
        deque_answer_t     answers [$];
        int                errors;
        int                accepted;

        function new();
            left_pos  = 0;
            right_pos = 0;
            held      = 0;
            mode      = MODE_IN_RESTRICTED;
            errors    = 0;
            accepted  = 0;
        endfunction

        function void set_mode(restrict_mode_t m);
            mode      = m;
            left_pos  = 0;
            right_pos = 0;
            held      = 0;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Predict the answer to one accepted request and queue it
        function void note_request(req_op_t op, logic [WORD_W-1:0] word);
            deque_answer_t ans;
            ans.status  = ST_OK;
            ans.removed = '0;
            accepted++;
            if ((mode == MODE_IN_RESTRICTED && op == OP_INS_L) ||
                (mode == MODE_OUT_RESTRICTED && op == OP_DEL_R)) begin
                ans.status = ST_NOT_ALLOWED;
            end else if (op == OP_INS_R || op == OP_INS_L) begin
                if (held >= DEPTH) begin
                    ans.status = ST_OVERFLOW;
                end else begin
                    if (held == 0) begin
                        left_pos  = 0;
                        right_pos = 0;
                        words[0]  = word;
                    end else if (op == OP_INS_R) begin
                        right_pos = (right_pos == DEPTH - 1) ? 0 : right_pos + 1;
                        words[right_pos] = word;
                    end else begin
                        left_pos = (left_pos == 0) ? DEPTH - 1 : left_pos - 1;
                        words[left_pos] = word;
                    end
                    held++;
                end
            end else begin
                if (held == 0) begin
                    ans.status = ST_UNDERFLOW;
                end else begin
                    if (op == OP_DEL_L) begin
                        ans.removed = words[left_pos];
                        left_pos    = (left_pos == DEPTH - 1) ? 0 : left_pos + 1;
                    end else begin
                        ans.removed = words[right_pos];
                        right_pos   = (right_pos == 0) ? DEPTH - 1 : right_pos - 1;
                    end
                    held--;
                    if (held == 0) begin
                        left_pos  = 0;
                        right_pos = 0;
                    end
                end
            end
            ans.fill = held[FILL_W-1:0];
            answers.push_back(ans);
        endfunction

        task check_result(logic [1:0] status, logic [WORD_W-1:0] removed,
                          logic [FILL_W-1:0] fill);
            deque_answer_t ans;
            if (answers.size() == 0) begin
                report_mismatch($sformatf("result with no request pending (status %0d)",
                                          status));
            end else begin
                ans = answers.pop_front();
                if (status !== ans.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              status, ans.status));
                if (removed !== ans.removed)
                    report_mismatch($sformatf("removed_value got %08h expected %08h",
                                              removed, ans.removed));
                if (fill !== ans.fill)
                    report_mismatch($sformatf("fill_count got %0d expected %0d",
                                              fill, ans.fill));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_req_type;
    logic signed [WORD_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_status;
    logic signed [WORD_W-1:0] m_removed_value;
    logic [FILL_W-1:0]        m_fill_count;

    deque_scoreboard board;
    int              cycles;
    int              hold_left;
    bit              hold_done;

    restricted_circular_deque #(.DEPTH(DEPTH)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_fill_count    (m_fill_count)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit take_break();
        if (cycles >= CALM_FROM && cycles < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 20;
    endfunction

    // Result side: check, then decide ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_status, m_removed_value, m_fill_count);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && board.accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !take_break();
        end
    end

    task automatic send_request(req_op_t op, logic [WORD_W-1:0] word);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= op;
        s_value    <= word;
        do @(posedge aclk); while (!s_ready);
        board.note_request(op, word);
    endtask

    // Drain outstanding requests, then write the mode register
    task automatic write_mode(restrict_mode_t m);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DEPTH + 2) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {31'd0, m};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_mode(m);
    endtask

    function automatic req_op_t pick_op(restrict_mode_t m, int ins_pct);
        bit side;
        side = $urandom_range(0, 1);
        // a few requests the mode forbids
        if ($urandom_range(0, 99) < 8)
            return (m == MODE_IN_RESTRICTED) ? OP_INS_L : OP_DEL_R;
        if ($urandom_range(0, 99) < ins_pct) begin
            if (m == MODE_IN_RESTRICTED)
                return OP_INS_R;
            return side ? OP_INS_R : OP_INS_L;
        end
        if (m == MODE_OUT_RESTRICTED)
            return OP_DEL_L;
        return side ? OP_DEL_L : OP_DEL_R;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    restrict_mode_t mode_plan [PHASES] = '{
        MODE_IN_RESTRICTED, MODE_OUT_RESTRICTED, MODE_OUT_RESTRICTED, MODE_IN_RESTRICTED,
        MODE_OUT_RESTRICTED, MODE_IN_RESTRICTED, MODE_IN_RESTRICTED, MODE_OUT_RESTRICTED
    };

    initial begin
        int ins_pct;
        board      = new();
        cycles     = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_req_type = OP_INS_R;
        s_value    = '0;
        m_ready    = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Input restricted after reset: empty deletes, forbidden left insert, extremes
        send_request(OP_DEL_L, 32'h1234_5678);
        send_request(OP_DEL_R, 32'h0);
        send_request(OP_INS_L, 32'hdead_beef);
        send_request(OP_INS_R, 32'h7fff_ffff);
        send_request(OP_INS_R, 32'h8000_0000);
        send_request(OP_DEL_R, 32'h0);
        send_request(OP_DEL_L, 32'hffff_ffff);

        // Output restricted: forbidden check beats underflow, left wrap, fill to overflow
        write_mode(MODE_OUT_RESTRICTED);
        send_request(OP_DEL_R, 32'h0);
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_INS_L, (i % 4 == 0) ? 32'hffff_ffff :
                                   (i % 4 == 1) ? 32'h0 : $urandom);
        send_request(OP_INS_R, 32'h5555_aaaa);

        for (int p = 0; p < PHASES; p++) begin
            write_mode(mode_plan[p]);
            for (int k = 0; k < PHASE_REQS; k++) begin
                // alternate filling and draining runs so both ends get hit often
                ins_pct = ((k / 20) % 2 == 0) ? 75 : 30;
                send_request(pick_op(mode_plan[p], ins_pct), pick_word());
            end
        end

        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
